// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/akms_pkg.sv =====
package akms_pkg;

  localparam int unsigned KMER_LEN_DEF     = 8;
  localparam int unsigned MAX_READ_LEN_DEF = 65536;

  // Command codes of an input word
  localparam logic CMD_ADAPTER = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Offset that maps 'A' to table slot zero; lowercase folds onto the same slot
  localparam logic [7:0] ASCII_OFFSET = 8'd65;

  localparam logic [1:0] BASE_CODE [32] = '{
    2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd3, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  // Encode one ASCII nucleotide: A=0, T=1, C=2, G=3, anything else 0
  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [4:0] slot;
    slot = 5'(ch - ASCII_OFFSET);
    return BASE_CODE[slot];
  endfunction

  // Bitmap access request
  typedef struct packed {
    logic rd_en;
    logic set_en;
  } map_req_t;

endpackage

// ===== src/akms_if.sv =====
// Input channel: one nucleotide word per handshake
interface akms_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] base_char;
  logic       last_base;

  modport source (output valid, command, base_char, last_base, input ready);
  modport sink   (input valid, command, base_char, last_base, output ready);
endinterface

// Result channel: one screening result per read
interface akms_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] hit_position;

  modport source (output valid, hit, hit_position, input ready);
  modport sink   (input valid, hit, hit_position, output ready);
endinterface

// ===== src/akms_bitmap.sv =====
module akms_bitmap
  import akms_pkg::*;
#(
  parameter int unsigned KBITS = 2 * KMER_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  map_req_t         req,
  input  logic [KBITS-1:0] addr,
  output logic             rd_bit,
  output logic             busy
);

  localparam int unsigned DEPTH = 1 << KBITS;

  logic             mem [DEPTH];
  logic             clr_r;
  logic [KBITS-1:0] clr_addr_r;
  logic             rd_bit_r;

  // Sweep the whole bitmap to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + KBITS'(1);
      if (clr_addr_r == {KBITS{1'b1}}) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Single write port: clear sweep or k-mer set
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= 1'b0;
    end else if (req.set_en) begin
      mem[addr] <= 1'b1;
    end
  end

  // Registered read, held until the next lookup
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_bit_r <= mem[addr];
    end
  end

  assign rd_bit = rd_bit_r;
  assign busy   = clr_r;

endmodule

// ===== src/adapter_kmer_screen.sv =====
// Adapter k-mer screen. Takes nucleotide words: adapter words (command 0) mark
// every complete k-mer of KMER_LEN bases in a bitmap, read words (command 1)
// look up each complete k-mer but the one at the last word, and the last word
// of a read yields one result with hit and the index of the base after the
// first matching k-mer. The sustained rate is one word per cycle while the
// result channel does not stall, each word making one lookup or one store; a
// result passes the lookup stage and result register once the last read word
// is taken. After reset the bitmap is swept clear, one entry per cycle over
// all 4^KMER_LEN entries (65536 at the default), while no word is accepted.
`include "assert_macros.svh"

module adapter_kmer_screen
  import akms_pkg::*;
#(
  parameter int unsigned KMER_LEN     = KMER_LEN_DEF,
  parameter int unsigned MAX_READ_LEN = MAX_READ_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  akms_in_if.sink    in_ch,
  akms_out_if.source out_ch
);

  localparam int unsigned KBITS  = 2 * KMER_LEN;
  localparam int unsigned POS_W  = $clog2(MAX_READ_LEN + 1);
  localparam int unsigned FPOS_W = $clog2(MAX_READ_LEN);

  // Sequence state
  logic [KBITS-1:0]  kmer_r;
  logic [KBITS-1:0]  kmer_cur;
  logic [KBITS-1:0]  kmer_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;

  // Lookup stage
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic              s1_last_r;
  logic              s1_elig_r;
  logic [FPOS_W-1:0] s1_fpos_r;
  logic              elig;

  // Match tracking
  logic              found_r;
  logic [FPOS_W-1:0] found_pos_r;

  // Result register
  logic              out_valid_r;
  logic              out_hit_r;
  logic [15:0]       out_pos_r;

  logic              in_fire;
  logic              in_ready;
  logic              s1_res;
  logic              s1_go;
  logic              out_free;
  map_req_t          map_req;
  logic              map_bit;
  logic              map_busy;

  assign in_fire  = in_ch.valid && in_ready;
  assign s1_res   = s1_valid_r && s1_last_r && (s1_cmd_r == CMD_READ);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_res || out_free);
  assign in_ready = !map_busy && (!s1_valid_r || s1_go);

  assign in_ch.ready = in_ready;

  // Roll the base into the k-mer, advance the position; last base clears both
  always_comb begin
    kmer_cur = {kmer_r[KBITS-3:0], base_code(in_ch.base_char)};
    elig     = (in_ch.command == CMD_READ) && !in_ch.last_base
               && (pos_r >= POS_W'(KMER_LEN - 1))
               && (pos_r < POS_W'(MAX_READ_LEN - 1));
    kmer_nxt = kmer_cur;
    pos_nxt  = pos_r;
    if (pos_r < POS_W'(MAX_READ_LEN)) begin
      pos_nxt = pos_r + POS_W'(1);
    end
    if (in_ch.last_base) begin
      kmer_nxt = '0;
      pos_nxt  = '0;
    end
  end

  always_comb begin
    map_req.set_en = in_fire && (in_ch.command == CMD_ADAPTER)
                     && (pos_r >= POS_W'(KMER_LEN - 1));
    map_req.rd_en  = in_fire && (in_ch.command == CMD_READ);
  end

  akms_bitmap #(
    .KBITS (KBITS)
  ) u_bitmap (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (map_req),
    .addr   (kmer_cur),
    .rd_bit (map_bit),
    .busy   (map_busy)
  );

  // Advance sequence state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_r <= '0;
      pos_r  <= '0;
    end else if (in_fire) begin
      kmer_r <= kmer_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Hold the word alongside its bitmap lookup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.command;
      s1_last_r <= in_ch.last_base;
      s1_elig_r <= elig;
      s1_fpos_r <= FPOS_W'(pos_r + POS_W'(1));
    end
  end

  // Record the first match of the read, drop it at sequence end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      found_pos_r <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        found_r     <= 1'b0;
        found_pos_r <= '0;
      end else if (s1_elig_r && map_bit && !found_r) begin
        found_r     <= 1'b1;
        found_pos_r <= s1_fpos_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_res) begin
      out_hit_r <= found_r;
      out_pos_r <= found_r ? 16'(found_pos_r) : 16'd0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.hit_position = out_pos_r;

  // No word enters while the bitmap is being swept
  `ASSERT_IMPLIES(a_no_accept_in_clear, clk, rst_n, map_busy, !in_ready)
  // A new result comes only from the last word of a read
  `ASSERT_IMPLIES(a_result_from_read_end, clk, rst_n, $rose(out_valid_r), $past(s1_res))
  // Match state is cleared once a sequence end leaves the lookup stage
  `ASSERT_IMPLIES(a_found_cleared, clk, rst_n, $past(s1_go && s1_last_r), !found_r)

endmodule
